@@ hw/rtl/pol_pkg.sv @@
`timescale 1ns / 1ps
// package for the positional ordered list
// holds operation and status codes, controller states and the command struct
package pol_pkg;

  localparam int DepthDefault = 32;
  localparam int ValueWidth = 32;
  localparam int PosWidth = 8;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_LIST      = 3'd6,
    OP_REVERSE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic scan_start;
    logic scan_step;
    logic rev;
  } cmd_t;

endpackage

@@ hw/rtl/pol_datapath.sv @@
`timescale 1ns / 1ps
// shift-register cell array, length counter and listing scan index
// depends on pol_pkg
module pol_datapath
  import pol_pkg::*;
#(
  parameter int DEPTH = DepthDefault,
  localparam int LW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [IW-1:0]         idx,
  input  logic [ValueWidth-1:0] value,
  output logic [LW-1:0]         length,
  output logic [ValueWidth-1:0] scan_data,
  output logic                  scan_last
);

  logic [ValueWidth-1:0] cells [DEPTH];
  logic [IW-1:0] scan_idx;
  logic [LW-1:0] scan_cnt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.ins) begin
        if (i == int'(idx)) begin
          cells[i] <= value;
        end else if (i > int'(idx) && i > 0) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.del) begin
        if (i >= int'(idx) && i < DEPTH - 1) begin
          cells[i] <= cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.ins) begin
      length <= length + LW'(1);
    end else if (cmd.del) begin
      length <= length - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= cmd.rev ? IW'(length - LW'(1)) : '0;
      scan_cnt <= length - LW'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= cmd.rev ? scan_idx - IW'(1) : scan_idx + IW'(1);
      scan_cnt <= scan_cnt - LW'(1);
    end
  end

  assign scan_data = cells[scan_idx];
  assign scan_last = (scan_cnt == '0);

endmodule

@@ hw/rtl/pol_ctrl.sv @@
`timescale 1ns / 1ps
// controller: request decode, status checks, output register and listing sequence
// depends on pol_pkg
module pol_ctrl
  import pol_pkg::*;
#(
  parameter int DEPTH = DepthDefault,
  localparam int LW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            operation,
  input  logic [PosWidth-1:0]   position,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [ValueWidth-1:0] element,
  output logic                  last,
  output cmd_t                  cmd,
  output logic [IW-1:0]         idx,
  input  logic [LW-1:0]         length,
  input  logic [ValueWidth-1:0] scan_data,
  input  logic                  scan_last
);

  state_t state, state_next;
  logic rev;
  logic out_free, in_acc, emit;
  logic is_list, ins_ok, del_ok;
  status_t st;
  logic [8:0] pos9, len9;

  assign out_free = !out_valid || !out_stall;
  assign pos9 = {1'b0, position};
  assign len9 = 9'(length);
  assign is_list = (operation == OP_LIST) || (operation == OP_REVERSE);

  always_comb begin
    st = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    idx = '0;
    unique case (op_t'(operation))
      OP_INS_FRONT, OP_INS_END: begin
        if (length == LW'(DEPTH)) st = ST_FULL;
        else ins_ok = 1'b1;
        idx = (operation == OP_INS_FRONT) ? '0 : IW'(length);
      end
      OP_INS_POS: begin
        if (position == '0) st = ST_INVALID;
        else if (pos9 > len9 + 9'd1) st = ST_RANGE;
        else if (length == LW'(DEPTH)) st = ST_FULL;
        else ins_ok = 1'b1;
        idx = IW'(position - 8'd1);
      end
      OP_DEL_FRONT, OP_DEL_END: begin
        if (length == '0) st = ST_EMPTY;
        else del_ok = 1'b1;
        idx = (operation == OP_DEL_FRONT) ? '0 : IW'(length - LW'(1));
      end
      OP_DEL_POS: begin
        if (length == '0) st = ST_EMPTY;
        else if (position == '0) st = ST_INVALID;
        else if (pos9 > len9) st = ST_RANGE;
        else del_ok = 1'b1;
        idx = IW'(position - 8'd1);
      end
      default: begin
        if (length == '0) st = ST_EMPTY;
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc && is_list && length != '0) state_next = S_LIST;
      S_LIST: if (out_free && scan_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    emit = 1'b0;
    cmd.rev = rev;
    unique case (state)
      S_IDLE: begin
        in_stall = !out_free;
        cmd.ins = in_acc && ins_ok;
        cmd.del = in_acc && del_ok;
        cmd.scan_start = in_acc && is_list;
        cmd.rev = (operation == OP_REVERSE);
      end
      S_LIST: begin
        emit = out_free;
        cmd.scan_step = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) out_valid <= !(is_list && length != '0);
      else if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rev <= (operation == OP_REVERSE);
      status <= st;
      element <= '0;
      last <= 1'b1;
    end else if (emit) begin
      status <= ST_OK;
      element <= scan_data;
      last <= scan_last;
    end
  end

endmodule

@@ hw/rtl/positional_ordered_list.sv @@
`timescale 1ns / 1ps
// positional ordered list top level: controller plus cell datapath
// an edit updates the cells and registers its result when it is accepted
// a listing of n values streams one value per cycle while the output is not stalled
// throughput: one edit per cycle unless the output stalls; a listing blocks input until its last value
// synchronous reset empties the list; cell contents are left as they are
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   operation,
  input  logic [PosWidth-1:0]          position,
  input  logic signed [ValueWidth-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic signed [ValueWidth-1:0] element,
  output logic                         last
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t cmd;
  logic [IW-1:0] idx;
  logic [LW-1:0] length;
  logic [ValueWidth-1:0] scan_data;
  logic scan_last;

  pol_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .operation, .position,
    .out_valid, .out_stall, .status, .element, .last,
    .cmd, .idx, .length, .scan_data, .scan_last
  );

  pol_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .idx, .value, .length, .scan_data, .scan_last
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the positional ordered list: directed edits and listings, then random traffic
// predicts every result with a queue model of the list; depends on pol_pkg and the block rtl
module tb_top
  import pol_pkg::*;
;

  localparam int Depth = 32;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] element;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = '0;
  logic [7:0] position = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic signed [31:0] element;
  logic last;

  logic [31:0] list_model[$];
  result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  positional_ordered_list #(.DEPTH(Depth)) dut (
    clk, rst, in_valid, in_stall, operation, position, value,
    out_valid, out_stall, status, element, last
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void push_status(status_t st);
    expected_results.push_back({st, 32'd0, 1'b1});
  endfunction

  // updates the list model and queues the results one request causes
  function automatic void predict_request(op_t op, logic [7:0] pos, logic [31:0] v);
    int n;
    n = list_model.size();
    case (op)
      OP_INS_FRONT, OP_INS_END: begin
        if (n >= Depth) push_status(ST_FULL);
        else begin
          if (op == OP_INS_FRONT) list_model.push_front(v);
          else list_model.push_back(v);
          push_status(ST_OK);
        end
      end
      OP_INS_POS: begin
        if (pos == 0) push_status(ST_INVALID);
        else if (pos > n + 1) push_status(ST_RANGE);
        else if (n >= Depth) push_status(ST_FULL);
        else begin
          list_model.insert(pos - 1, v);
          push_status(ST_OK);
        end
      end
      OP_DEL_FRONT, OP_DEL_END: begin
        if (n == 0) push_status(ST_EMPTY);
        else begin
          if (op == OP_DEL_FRONT) void'(list_model.pop_front());
          else void'(list_model.pop_back());
          push_status(ST_OK);
        end
      end
      OP_DEL_POS: begin
        if (n == 0) push_status(ST_EMPTY);
        else if (pos == 0) push_status(ST_INVALID);
        else if (pos > n) push_status(ST_RANGE);
        else begin
          list_model.delete(pos - 1);
          push_status(ST_OK);
        end
      end
      default: begin
        if (n == 0) push_status(ST_EMPTY);
        else for (int i = 0; i < n; i++)
          expected_results.push_back({ST_OK,
            list_model[op == OP_LIST ? i : n - 1 - i], 1'(i == n - 1)});
      end
    endcase
  endfunction

  task automatic send_request(op_t op, logic [7:0] pos, logic [31:0] v);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    position <= pos;
    value <= v;
    // stall is stable between the falling edge and the next rising edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_request(op, pos, v);
  endtask

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 18));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d element %0d", status, element);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status);
          errors++;
        end
        if (element !== exp_r.element) begin
          $error("element expected %0d actual %0d", $signed(exp_r.element), element);
          errors++;
        end
        if (last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, last);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_cases();
    send_request(OP_DEL_FRONT, 0, 0);
    send_request(OP_DEL_END, 0, 0);
    send_request(OP_DEL_POS, 0, 0);
    send_request(OP_DEL_POS, 8'hff, 0);
    send_request(OP_LIST, 0, 0);
    send_request(OP_REVERSE, 0, 0);
    send_request(OP_INS_POS, 0, 5);
    send_request(OP_INS_POS, 2, 5);
  endtask

  task automatic test_edits();
    send_request(OP_INS_POS, 1, 32'h7fff_ffff);
    send_request(OP_INS_FRONT, 8'hff, 32'h8000_0000);
    send_request(OP_INS_END, 8'haa, 32'hffff_ffff);
    send_request(OP_INS_POS, 3, 32'h5555_aaaa);
    send_request(OP_INS_POS, 5, 32'haaaa_5555);
    send_request(OP_LIST, 0, 0);
    send_request(OP_REVERSE, 0, 0);
    send_request(OP_DEL_POS, 0, 0);
    send_request(OP_DEL_POS, 6, 0);
    send_request(OP_DEL_POS, 2, 0);
    send_request(OP_DEL_FRONT, 0, 0);
    send_request(OP_DEL_END, 0, 0);
    send_request(OP_LIST, 0, 0);
  endtask

  task automatic test_full();
    while (list_model.size() < Depth) send_request(OP_INS_END, 0, rand_value());
    send_request(OP_INS_FRONT, 0, 1);
    send_request(OP_INS_END, 0, 2);
    send_request(OP_INS_POS, 8'(Depth + 1), 3);
    send_request(OP_INS_POS, 0, 3);
    send_request(OP_INS_POS, 8'(Depth + 2), 3);
    send_request(OP_REVERSE, 0, 0);
    send_request(OP_DEL_POS, 8'(Depth), 0);
    send_request(OP_DEL_POS, 1, 0);
    send_request(OP_LIST, 0, 0);
  endtask

  task automatic test_random(int count);
    op_t op;
    int n;
    logic [7:0] pos;
    for (int k = 0; k < count; k++) begin
      if (k > count * 4 / 5) idle_on = 1'b0;
      n = list_model.size();
      // lean toward inserts when short and deletes when long
      if ($urandom_range(0, 9) == 0) op = op_t'($urandom_range(6, 7));
      else if ($urandom_range(0, Depth) >= n) op = op_t'($urandom_range(0, 2));
      else op = op_t'($urandom_range(3, 5));
      case ($urandom_range(0, 5))
        0: pos = 8'($urandom);
        1: pos = 0;
        default: pos = 8'($urandom_range(1, n + 2));
      endcase
      send_request(op, pos, rand_value());
    end
    send_request(OP_LIST, 0, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_cases();
    test_edits();
    test_full();
    test_random(300);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
